// ===== design/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

    localparam int unsigned CfgIdxW   = 1;
    localparam int unsigned CfgDataW  = 8;
    localparam int unsigned InTdataW  = 8;
    localparam int unsigned OutTdataW = 8;

    localparam logic [7:0] LongLimitReset   = 8'd180;
    localparam logic [7:0] ClickWindowReset = 8'd50;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_LONG_LIMIT   = 1'b0,
        CFG_CLICK_WINDOW = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KEY_RELEASED = 2'd0,
        KEY_UP       = 2'd1,
        KEY_DOWN     = 2'd2
    } t_key;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SHORT  = 3'd1,
        EV_LONG   = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_TRIPLE = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        SC_IDLE    = 3'd0,
        SC_CHANGE  = 3'd1,
        SC_STABLE  = 3'd2,
        SC_HOLD    = 3'd3,
        SC_RELEASE = 3'd4
    } t_scan_state;

    typedef enum logic [1:0] {
        CK_IDLE = 2'd0,
        CK_ONE  = 2'd1,
        CK_TWO  = 2'd2
    } t_click_state;

    typedef struct packed {
        t_key   key;
        t_event ev;
    } t_key_ev;

endpackage

`default_nettype wire

// ===== design/bcc_scan.sv =====
`default_nettype none

module bcc_scan
    import bcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic       i_up_level,
    input  wire logic       i_down_level,
    input  wire logic [7:0] i_long_limit,
    output t_key_ev         o_ev
);

    t_scan_state r_state, n_state;
    t_key        r_prev_key;
    logic [7:0]  r_hold, n_hold;
    t_key        now_key;
    logic        same;

    always_comb begin
        if (i_up_level) begin
            now_key = KEY_UP;
        end else if (!i_down_level) begin
            now_key = KEY_DOWN;
        end else begin
            now_key = KEY_RELEASED;
        end
    end

    assign same = (now_key == r_prev_key);

    always_comb begin
        n_state = r_state;
        n_hold  = r_hold;
        o_ev    = '{key: KEY_RELEASED, ev: EV_NONE};
        case (r_state)
            SC_IDLE: begin
                if (!same) n_state = SC_CHANGE;
            end
            SC_CHANGE: begin
                n_state = same ? SC_STABLE : SC_IDLE;
            end
            SC_STABLE: begin
                if (same) begin
                    n_state = SC_HOLD;
                end else begin
                    n_state = SC_IDLE;
                    o_ev    = '{key: r_prev_key, ev: EV_SHORT};
                end
            end
            SC_HOLD: begin
                if (same) begin
                    if (r_hold > i_long_limit) begin
                        n_hold  = '0;
                        n_state = SC_RELEASE;
                        o_ev    = '{key: r_prev_key, ev: EV_LONG};
                    end else begin
                        n_hold = r_hold + 8'd1;
                    end
                end else begin
                    n_hold  = '0;
                    n_state = SC_IDLE;
                    o_ev    = '{key: r_prev_key, ev: EV_SHORT};
                end
            end
            SC_RELEASE: begin
                if (!same) n_state = SC_IDLE;
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SC_IDLE;
            r_prev_key <= KEY_RELEASED;
            r_hold     <= '0;
        end else if (i_en) begin
            r_state    <= n_state;
            r_prev_key <= now_key;
            r_hold     <= n_hold;
        end
    end

`ifndef SYNTH
    a_hold_only_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold != 8'd0) |-> (r_state == SC_HOLD))
        else $error("hold counter nonzero outside holding");
    a_long_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_ev.ev == EV_LONG) |=> (r_state == SC_RELEASE && r_hold == 8'd0))
        else $error("long press did not move to wait release");
    a_short_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_ev.ev == EV_SHORT) |=> (r_state == SC_IDLE))
        else $error("short press did not return to idle");
`endif

endmodule

`default_nettype wire

// ===== design/bcc_click.sv =====
`default_nettype none

module bcc_click
    import bcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire t_key_ev    i_ev,
    input  wire logic [7:0] i_window,
    output t_key_ev         o_res
);

    t_click_state r_state, n_state;
    logic [7:0]   r_count, n_count;
    t_key         r_key, n_key;
    logic [7:0]   count_inc;
    logic         same_click;
    t_key_ev      res;

    assign count_inc  = r_count + 8'd1;
    assign same_click = (i_ev.ev == EV_SHORT) && (i_ev.key == r_key);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_key   = r_key;
        res     = '{key: KEY_RELEASED, ev: EV_NONE};
        case (r_state)
            CK_IDLE: begin
                if (i_ev.ev == EV_SHORT) begin
                    n_key   = i_ev.key;
                    n_count = '0;
                    n_state = CK_ONE;
                end else begin
                    res = i_ev;
                end
            end
            CK_ONE: begin
                if (same_click) begin
                    n_count = '0;
                    n_state = CK_TWO;
                end else begin
                    n_count = count_inc;
                    if (count_inc >= i_window) begin
                        res     = '{key: r_key, ev: EV_SHORT};
                        n_state = CK_IDLE;
                    end
                end
            end
            CK_TWO: begin
                if (same_click) begin
                    res     = '{key: r_key, ev: EV_TRIPLE};
                    n_state = CK_IDLE;
                end else begin
                    n_count = count_inc;
                    if (count_inc >= i_window) begin
                        res     = '{key: r_key, ev: EV_DOUBLE};
                        n_state = CK_IDLE;
                    end
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
        o_res = res;
        if (res.ev == EV_NONE) o_res.key = KEY_RELEASED;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CK_IDLE;
            r_count <= '0;
            r_key   <= KEY_RELEASED;
        end else if (i_en) begin
            r_state <= n_state;
            r_count <= n_count;
            r_key   <= n_key;
        end
    end

endmodule

`default_nettype wire

// ===== design/button_click_classifier.sv =====
// Channel   | Dir | Word
// s_axis    | in  | tdata[0] up_level, tdata[1] down_level, tdata[7:2] zero
// m_axis    | out | tdata[1:0] key_id, tdata[4:2] event_res, tdata[7:5] zero
// cfg       | in  | i_cfg_we, i_cfg_idx (0 long_press_limit, 1 click_window)
//
// One word per cycle unless stalled; one result word per input word.
// State advances and the result is registered on accept.
// s_axis_tready drops only while a result is held and m_axis_tready is low.
// Synchronous active-low i_rst_n resets every register except r_out.
`default_nettype none

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter logic [7:0] LONG_LIMIT_RESET   = LongLimitReset,
    parameter logic [7:0] CLICK_WINDOW_RESET = ClickWindowReset
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CfgIdxW-1:0]   i_cfg_idx,
    input  wire logic [CfgDataW-1:0]  i_cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // up_level, down_level, zero pad
    input  wire logic [InTdataW-1:0]  s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // key_id, event_res, zero pad
    output logic [OutTdataW-1:0]      m_axis_tdata
);

    logic [7:0] r_long_limit;
    logic [7:0] r_click_window;
    logic       r_out_valid;
    t_key_ev    r_out;
    logic       accept;
    t_key_ev    scan_ev;
    t_key_ev    click_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_limit   <= LONG_LIMIT_RESET;
            r_click_window <= CLICK_WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LONG_LIMIT:   r_long_limit   <= i_cfg_wdata[7:0];
                CFG_CLICK_WINDOW: r_click_window <= i_cfg_wdata[7:0];
                default:          r_long_limit   <= r_long_limit;
            endcase
        end
    end

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bcc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_up_level   (s_axis_tdata[0]),
        .i_down_level (s_axis_tdata[1]),
        .i_long_limit (r_long_limit),
        .o_ev         (scan_ev)
    );

    bcc_click u_click (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_ev     (scan_ev),
        .i_window (r_click_window),
        .o_res    (click_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_out <= click_res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutTdataW - 5){1'b0}}, r_out.ev, r_out.key};

`ifndef SYNTH
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted word produced no result");
    a_no_event_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ev == EV_NONE) |-> (r_out.key == KEY_RELEASED))
        else $error("key reported without event");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("input stalled with empty output register");
`endif

endmodule

`default_nettype wire
